// ===== hw/rtl/wds_pkg.sv =====
// Shared types and constants for the weighted discrete sampler.
// Used by the channel interfaces, the shared add/subtract unit and the top level.
// No dependencies.
package wds_pkg;

  // Default sizing of the weight table.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the channels and configuration port.
  localparam int MODE_W     = 1;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int U_W        = 16;
  localparam int PROB_W     = 16;
  localparam int STAT_W     = 1;
  localparam int EIU_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [MODE_W-1:0]    MODE_LOAD = 1'b0;
  localparam logic [MODE_W-1:0]    MODE_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EIU   = 1'd1;

  localparam logic [STAT_W-1:0]    STAT_OK    = 1'b0;
  localparam logic [STAT_W-1:0]    STAT_EMPTY = 1'b1;

  localparam logic [PROB_W-1:0]    PROB_MAX = 16'hFFFF;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } wds_alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDMOD,
    ST_SUM,
    ST_MUL,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } wds_state_t;

endpackage

// ===== hw/rtl/wds_if.sv =====
// Valid/ready channel interfaces for the sampler's input and result beats.
// Field widths come from wds_pkg.
interface wds_in_if;
  logic                         valid;
  logic                         ready;
  logic [wds_pkg::MODE_W-1:0]   mode;
  logic [wds_pkg::IDX_W-1:0]    entry_index;
  logic [wds_pkg::VAL_W-1:0]    weight_value;
  logic [wds_pkg::U_W-1:0]      uniform_sample;

  modport source (output valid, output mode, output entry_index, output weight_value,
                  output uniform_sample, input ready);
  modport sink   (input valid, input mode, input entry_index, input weight_value,
                  input uniform_sample, output ready);
endinterface

interface wds_out_if;
  logic                         valid;
  logic                         ready;
  logic [wds_pkg::IDX_W-1:0]    chosen_index;
  logic [wds_pkg::PROB_W-1:0]   probability;
  logic [wds_pkg::STAT_W-1:0]   status;

  modport source (output valid, output chosen_index, output probability, output status,
                  input ready);
  modport sink   (input valid, input chosen_index, input probability, input status,
                  output ready);
endinterface

// ===== hw/rtl/weighted_discrete_sampler.sv =====
// Top level of the weighted discrete sampler: weight table, sequencer and result register.
// Depends on wds_pkg, wds_if (wds_in_if, wds_out_if) and wds_alu.
//
//  channel  | direction | beat contents
//  in_bus   | sink      | mode, entry_index, weight_value, uniform_sample
//  out_bus  | source    | chosen_index, probability, status (one beat per draw)
//  cfg_*    | write     | cfg_index selects weights_normalized or entries_in_use
//
// A load passes through ST_LDMOD, which reduces the index by repeated subtraction when
// MAX_ENTRIES is below 64, and then writes the table. A normalized draw runs a search
// walk over the entries in use; an unnormalized one a sum walk, 16 shift-add steps,
// a search walk and 17 division steps. Sums, products and quotients share one adder.
// in_bus.ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next draw stalls at its end until that beat is taken.
// Reset (synchronous, rst_n low) clears control state; the table is not cleared.
module weighted_discrete_sampler #(
  parameter int MAX_ENTRIES = wds_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wds_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wds_in_if.sink                           in_bus,
  wds_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [wds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUMW   = WEIGHT_BITS + AW;
  localparam int PW     = SUMW + wds_pkg::U_W;
  localparam int STEP_W = $clog2(wds_pkg::PROB_W + 1);

  // Configuration registers.
  logic                          norm_r;
  logic [wds_pkg::EIU_W-1:0]     eiu_r;

  // Sequencer and datapath registers.
  wds_pkg::wds_state_t           state_r, state_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [AW-1:0]                 last_r, last_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [SUMW-1:0]               sum_r, sum_nxt;
  logic [SUMW-1:0]               cum_r, cum_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [PW-1:0]                 mcand_r, mcand_nxt;
  logic [wds_pkg::U_W-1:0]       u_r, u_nxt;
  logic [WEIGHT_BITS-1:0]        w_r, w_nxt;
  logic [SUMW-1:0]               rem_r, rem_nxt;
  logic [wds_pkg::PROB_W:0]      q_r, q_nxt;
  logic [AW-1:0]                 pick_r, pick_nxt;
  logic [wds_pkg::PROB_W-1:0]    prob_r, prob_nxt;
  logic [wds_pkg::STAT_W-1:0]    stat_r, stat_nxt;
  logic [wds_pkg::IDX_W-1:0]     ld_idx_r, ld_idx_nxt;
  logic [WEIGHT_BITS-1:0]        ld_w_r, ld_w_nxt;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic [wds_pkg::IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [wds_pkg::PROB_W-1:0]    out_prob_r, out_prob_nxt;
  logic [wds_pkg::STAT_W-1:0]    out_stat_r, out_stat_nxt;

  // Weight table.
  logic [WEIGHT_BITS-1:0]        mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0]        rdata_r;
  logic                          mem_we;

  // Shared adder.
  wds_pkg::wds_alu_op_t          alu_op;
  logic [PW-1:0]                 alu_a, alu_b;
  logic [PW:0]                   alu_res;

  logic                          in_fire;
  logic [PW-1:0]                 dvd;
  logic                          hit;

  wds_alu #(.W(PW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_bus.ready         = (state_r == wds_pkg::ST_IDLE);
  assign in_fire              = in_bus.valid && in_bus.ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.chosen_index = out_idx_r;
  assign out_bus.probability  = out_prob_r;
  assign out_bus.status       = out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b0;
      eiu_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wds_pkg::CFG_NORM: norm_r <= cfg_data[0];
        wds_pkg::CFG_EIU:  eiu_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The read address is the next walk index, so during the table walks rdata_r holds mem[idx_r].
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(ld_idx_r)] <= ld_w_r;
    end
    rdata_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    step_r     <= step_nxt;
    sum_r      <= sum_nxt;
    cum_r      <= cum_nxt;
    prod_r     <= prod_nxt;
    mcand_r    <= mcand_nxt;
    u_r        <= u_nxt;
    w_r        <= w_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    pick_r     <= pick_nxt;
    prob_r     <= prob_nxt;
    stat_r     <= stat_nxt;
    ld_idx_r   <= ld_idx_nxt;
    ld_w_r     <= ld_w_nxt;
    out_idx_r  <= out_idx_nxt;
    out_prob_r <= out_prob_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    cum_nxt       = cum_r;
    prod_nxt      = prod_r;
    mcand_nxt     = mcand_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    pick_nxt      = pick_r;
    prob_nxt      = prob_r;
    stat_nxt      = stat_r;
    ld_idx_nxt    = ld_idx_r;
    ld_w_nxt      = ld_w_r;
    out_idx_nxt   = out_idx_r;
    out_prob_nxt  = out_prob_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    mem_we        = 1'b0;
    alu_op        = wds_pkg::ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    dvd           = (step_r == '0) ? PW'(w_r) : PW'({rem_r, 1'b0});
    hit           = 1'b0;

    case (state_r)
      wds_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.mode == wds_pkg::MODE_LOAD) begin
            ld_idx_nxt = in_bus.entry_index;
            ld_w_nxt   = WEIGHT_BITS'(in_bus.weight_value);
            state_nxt  = wds_pkg::ST_LDMOD;
          end else begin
            u_nxt    = in_bus.uniform_sample;
            idx_nxt  = '0;
            sum_nxt  = '0;
            cum_nxt  = '0;
            prod_nxt = '0;
            step_nxt = '0;
            stat_nxt = wds_pkg::STAT_OK;
            if (32'(eiu_r) > MAX_ENTRIES) begin
              last_nxt = AW'(MAX_ENTRIES - 1);
            end else begin
              last_nxt = AW'(eiu_r - 7'd1);
            end
            if (eiu_r == '0) begin
              pick_nxt  = '0;
              prob_nxt  = '0;
              stat_nxt  = wds_pkg::STAT_EMPTY;
              state_nxt = wds_pkg::ST_DONE;
            end else if (norm_r) begin
              state_nxt = wds_pkg::ST_SCAN;
            end else begin
              state_nxt = wds_pkg::ST_SUM;
            end
          end
        end
      end

      // Reduce the load index modulo the table depth, then write.
      wds_pkg::ST_LDMOD: begin
        if (32'(ld_idx_r) >= MAX_ENTRIES) begin
          ld_idx_nxt = ld_idx_r - wds_pkg::IDX_W'(MAX_ENTRIES);
        end else begin
          mem_we    = 1'b1;
          state_nxt = wds_pkg::ST_IDLE;
        end
      end

      wds_pkg::ST_SUM: begin
        alu_a   = PW'(sum_r);
        alu_b   = PW'(rdata_r);
        sum_nxt = alu_res[SUMW-1:0];
        if (idx_r == last_r) begin
          idx_nxt   = '0;
          mcand_nxt = PW'(alu_res[SUMW-1:0]);
          state_nxt = wds_pkg::ST_MUL;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // Shift-add product of the sample and the sum, one sample bit per cycle.
      wds_pkg::ST_MUL: begin
        alu_a     = prod_r;
        alu_b     = u_r[0] ? mcand_r : '0;
        prod_nxt  = alu_res[PW-1:0];
        mcand_nxt = {mcand_r[PW-2:0], 1'b0};
        u_nxt     = {1'b0, u_r[wds_pkg::U_W-1:1]};
        if (step_r == STEP_W'(wds_pkg::U_W - 1)) begin
          step_nxt  = '0;
          state_nxt = wds_pkg::ST_SCAN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      wds_pkg::ST_SCAN: begin
        alu_a   = PW'(cum_r);
        alu_b   = PW'(rdata_r);
        cum_nxt = alu_res[SUMW-1:0];
        if (norm_r) begin
          hit = PW'(u_r) < alu_res[PW-1:0];
        end else begin
          hit = prod_r < {alu_res[SUMW-1:0], {wds_pkg::U_W{1'b0}}};
        end
        if (hit || idx_r == last_r) begin
          pick_nxt = idx_r;
          w_nxt    = rdata_r;
          step_nxt = '0;
          if (norm_r) begin
            prob_nxt  = (32'(rdata_r) > 32'(wds_pkg::PROB_MAX)) ?
                        wds_pkg::PROB_MAX : wds_pkg::PROB_W'(rdata_r);
            state_nxt = wds_pkg::ST_DONE;
          end else if (sum_r == '0) begin
            prob_nxt  = '0;
            state_nxt = wds_pkg::ST_DONE;
          end else begin
            state_nxt = wds_pkg::ST_DIV;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // Restoring division of w * 2^16 by the sum; the chosen weight never
      // exceeds the sum, so the quotient needs only 17 bits.
      wds_pkg::ST_DIV: begin
        alu_op  = wds_pkg::ALU_SUB;
        alu_a   = dvd;
        alu_b   = PW'(sum_r);
        rem_nxt = alu_res[PW] ? alu_res[SUMW-1:0] : dvd[SUMW-1:0];
        q_nxt   = {q_r[wds_pkg::PROB_W-1:0], alu_res[PW]};
        if (step_r == STEP_W'(wds_pkg::PROB_W)) begin
          prob_nxt  = q_r[wds_pkg::PROB_W-1] ? wds_pkg::PROB_MAX :
                      {q_r[wds_pkg::PROB_W-2:0], alu_res[PW]};
          state_nxt = wds_pkg::ST_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end

      wds_pkg::ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_idx_nxt   = wds_pkg::IDX_W'(pick_r);
          out_prob_nxt  = prob_r;
          out_stat_nxt  = stat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = wds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wds_pkg::ST_IDLE;
      end
    endcase
  end

  a_empty_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == wds_pkg::STAT_EMPTY) |->
      (out_prob_r == '0 && out_idx_r == '0))
    else $error("empty-table beat carries a nonzero index or probability");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wds_pkg::ST_SUM || state_r == wds_pkg::ST_SCAN) |-> (idx_r <= last_r))
    else $error("table walk ran past the last entry in use");

  a_rem_below_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wds_pkg::ST_DIV && step_r != '0) |-> (rem_r < sum_r))
    else $error("division remainder not below the divisor");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.mode == wds_pkg::MODE_DRAW) |=> !in_bus.ready)
    else $error("draw accepted but sequencer returned to idle at once");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wds_pkg::ST_DONE && out_valid_r && !out_bus.ready) |=>
      (state_r == wds_pkg::ST_DONE))
    else $error("finished draw left its state while the result register was full");

endmodule

// ===== hw/rtl/wds_alu.sv =====
// Shared add/subtract unit of the sampler datapath, with carry out.
// Depends on wds_pkg for the operation code.
module wds_alu #(
  parameter int W = 60
) (
  input  wds_pkg::wds_alu_op_t op,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output logic [W:0]           res
);

  logic [W-1:0] b_eff;
  logic         cin;

  // Subtraction is a + ~b + 1; the carry out is then set when a >= b.
  assign b_eff = (op == wds_pkg::ALU_SUB) ? ~b : b;
  assign cin   = (op == wds_pkg::ALU_SUB);
  assign res   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};

endmodule
